// File: hdl/gpe_pkg.sv
// ----------------------------------------------------------------------------
// gpe_pkg: shared definitions for the gradient palette entry block
// Register indexes, field widths and default limits.
// ----------------------------------------------------------------------------
`default_nettype none

package gpe_pkg;

    // default limits for the top level parameters
    localparam int MAX_STOPS_DEF = 8;
    localparam int MAX_STEPS_DEF = 4096;

    // fixed field widths
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 4;
    localparam int STEPS_W = 13;
    localparam int PAIR_W  = 48;
    localparam int STOP_W  = 24;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int ARGB_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CH_W-1:0] ALPHA = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT = 3'd0,
        REG_STEP_COUNT = 3'd1,
        REG_PAIR_0     = 3'd2,
        REG_PAIR_1     = 3'd3,
        REG_PAIR_2     = 3'd4,
        REG_PAIR_3     = 3'd5
    } cfg_reg_t;

    localparam logic [CNT_W-1:0]   STOP_COUNT_RST = 4'd8;
    localparam logic [STEPS_W-1:0] STEP_COUNT_RST = 13'd256;

endpackage

`default_nettype wire

// File: hdl/gpe_cell.sv
// ----------------------------------------------------------------------------
// gpe_cell: one restoring division cell
// Resolves one quotient bit for each lane and hands the partial result on.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_cell #(
    parameter int LANES = 1,
    parameter int NW    = 15,
    parameter int DW    = 12,
    parameter int QW    = 3,
    parameter int BIT   = 0,
    parameter int SW    = 3
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [LANES-1:0][NW-1:0]  in_rem,
    input  wire logic [LANES-1:0][QW-1:0]  in_quot,
    input  wire logic [DW-1:0]             in_div,
    input  wire logic [SW-1:0]             in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][NW-1:0]       out_rem,
    output logic [LANES-1:0][QW-1:0]       out_quot,
    output logic [DW-1:0]                  out_div,
    output logic [SW-1:0]                  out_side
);

    localparam int CW = NW + DW + QW;

    logic                      valid_reg;
    logic [LANES-1:0][NW-1:0]  rem_reg,  rem_next;
    logic [LANES-1:0][QW-1:0]  quot_reg, quot_next;
    logic [DW-1:0]             div_reg;
    logic [SW-1:0]             side_reg;
    logic [CW-1:0]             trial;

    // trial subtract of the shifted divisor in every lane
    always_comb
    begin
        trial = CW'(in_div) << BIT;
        for (int l = 0; l < LANES; l++)
        begin
            if (CW'(in_rem[l]) >= trial)
            begin
                rem_next[l]  = NW'(CW'(in_rem[l]) - trial);
                quot_next[l] = in_quot[l] | (QW'(1) << BIT);
            end
            else
            begin
                rem_next[l]  = in_rem[l];
                quot_next[l] = in_quot[l];
            end
        end
    end

    // advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // hold the partial result for the next cell
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= in_div;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quot  = quot_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

    // remainder stays below the divisor at this bit weight
    for (genvar l = 0; l < LANES; l++)
    begin : g_chk
        a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg |-> (CW'(rem_reg[l]) < (CW'(div_reg) << BIT)))
            else $error("division remainder out of bound");
    end

endmodule

`default_nettype wire

// File: hdl/gpe_mix.sv
// ----------------------------------------------------------------------------
// gpe_mix: stop selection and weighted sum
// Picks the two stops around the position and forms the rounding numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_mix #(
    parameter int QW  = 3,
    parameter int DW  = 12,
    parameter int NW1 = 15
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic [QW-1:0]                         in_quot,
    input  wire logic [NW1-1:0]                        in_rem,
    input  wire logic [DW-1:0]                         in_div,
    input  wire logic [QW-1:0]                         in_smax,
    input  wire logic [(2**QW)-1:0][gpe_pkg::STOP_W-1:0] stops,
    output logic                                       out_valid,
    output logic [gpe_pkg::NUM_CH-1:0][DW+8:0]         out_num,
    output logic [DW:0]                                out_div2
);

    import gpe_pkg::*;

    localparam int SW = DW + 8;

    logic                         valid_reg;
    logic [NUM_CH-1:0][DW+8:0]    num_reg, num_next;
    logic [DW:0]                  div2_reg;
    logic [QW-1:0]                k2;
    logic [DW-1:0]                r;
    logic [DW-1:0]                w1;
    logic [STOP_W-1:0]            s1, s2;
    logic [SW-1:0]                sum;

    // select neighbor stops and blend each channel
    always_comb
    begin
        r  = DW'(in_rem);
        w1 = in_div - r;
        k2 = (in_quot == in_smax) ? in_smax : in_quot + QW'(1);
        s1 = stops[in_quot];
        s2 = stops[k2];
        sum = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum = SW'(w1) * SW'(s1[c*CH_W +: CH_W]) + SW'(r) * SW'(s2[c*CH_W +: CH_W]);
            num_next[c] = {sum, 1'b0} + (DW+9)'(in_div);
        end
    end

    // advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // hold numerators and doubled divisor
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        div2_reg <= {in_div, 1'b0};
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_div2  = div2_reg;

endmodule

`default_nettype wire

// File: hdl/gradient_palette_entry.sv
// ----------------------------------------------------------------------------
// gradient_palette_entry: one entry of a multi-stop linear color gradient
// Front stage, stop-position divider cells, blend stage, channel divider cells.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy stays low, the cell chain is fully
// pipelined with one quotient bit resolved per cell.
// Results appear on done for one cycle; the receiver cannot stall.
// Reset clears all valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_palette_entry #(
    parameter int MAX_STOPS = gpe_pkg::MAX_STOPS_DEF,
    parameter int MAX_STEPS = gpe_pkg::MAX_STEPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [gpe_pkg::IDX_W-1:0]       step_index,
    output logic                                 done,
    output logic [gpe_pkg::ARGB_W-1:0]           colour_argb,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gpe_pkg::PAIR_W-1:0]      cfg_data
);

    import gpe_pkg::*;

    localparam int QW   = $clog2(MAX_STOPS);
    localparam int DW   = $clog2(MAX_STEPS);
    localparam int NW1  = IDX_W + QW;
    localparam int NW2  = DW + 9;
    localparam int NSTOP = 2 ** QW;
    localparam int LAT  = QW + 10;

    // configuration registers
    logic [CNT_W-1:0]     stop_count_reg;
    logic [STEPS_W-1:0]   step_count_reg;
    logic [3:0][PAIR_W-1:0] pair_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_RST;
            step_count_reg <= STEP_COUNT_RST;
            pair_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STOP_COUNT: stop_count_reg <= cfg_data[CNT_W-1:0];
                REG_STEP_COUNT: step_count_reg <= cfg_data[STEPS_W-1:0];
                REG_PAIR_0:     pair_reg[0]    <= cfg_data;
                REG_PAIR_1:     pair_reg[1]    <= cfg_data;
                REG_PAIR_2:     pair_reg[2]    <= cfg_data;
                REG_PAIR_3:     pair_reg[3]    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // unpack stops
    logic [NSTOP-1:0][STOP_W-1:0] stops;
    always_comb
    begin
        for (int k = 0; k < NSTOP; k++)
            stops[k] = pair_reg[k >> 1][(k & 1) * STOP_W +: STOP_W];
    end

    // front stage: clamp and scale the index
    logic            front_valid_reg;
    logic [NW1-1:0]  front_num_reg, front_num_next;
    logic [DW-1:0]   front_d_reg, front_d_next;
    logic [QW-1:0]   front_smax_reg, front_smax_next;
    logic [IDX_W-1:0] idx;
    int              sc, st;

    always_comb
    begin
        sc = int'(stop_count_reg);
        if (sc < 1)
            sc = 1;
        if (sc > MAX_STOPS)
            sc = MAX_STOPS;
        st = int'(step_count_reg);
        if (st < 2)
            st = 2;
        if (st > MAX_STEPS)
            st = MAX_STEPS;
        front_smax_next = QW'(sc - 1);
        front_d_next    = DW'(st - 1);
        if (int'(step_index) > st - 1)
            idx = IDX_W'(st - 1);
        else
            idx = step_index;
        front_num_next = NW1'(idx) * NW1'(front_smax_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        front_num_reg  <= front_num_next;
        front_d_reg    <= front_d_next;
        front_smax_reg <= front_smax_next;
    end

    // stop position divider chain
    logic [QW:0]                d1_valid;
    logic [QW:0][NW1-1:0]       d1_rem;
    logic [QW:0][QW-1:0]        d1_quot;
    logic [QW:0][DW-1:0]        d1_div;
    logic [QW:0][QW-1:0]        d1_side;

    assign d1_valid[0] = front_valid_reg;
    assign d1_rem[0]   = front_num_reg;
    assign d1_quot[0]  = '0;
    assign d1_div[0]   = front_d_reg;
    assign d1_side[0]  = front_smax_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_pos
        gpe_cell #(
            .LANES(1), .NW(NW1), .DW(DW), .QW(QW), .BIT(QW - 1 - i), .SW(QW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (d1_valid[i]),
            .in_rem   (d1_rem[i]),
            .in_quot  (d1_quot[i]),
            .in_div   (d1_div[i]),
            .in_side  (d1_side[i]),
            .out_valid(d1_valid[i+1]),
            .out_rem  (d1_rem[i+1]),
            .out_quot (d1_quot[i+1]),
            .out_div  (d1_div[i+1]),
            .out_side (d1_side[i+1])
        );
    end

    // blend stage
    logic                           mix_valid;
    logic [NUM_CH-1:0][NW2-1:0]     mix_num;
    logic [DW:0]                    mix_div2;

    gpe_mix #(.QW(QW), .DW(DW), .NW1(NW1)) u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d1_valid[QW]),
        .in_quot  (d1_quot[QW]),
        .in_rem   (d1_rem[QW]),
        .in_div   (d1_div[QW]),
        .in_smax  (d1_side[QW]),
        .stops    (stops),
        .out_valid(mix_valid),
        .out_num  (mix_num),
        .out_div2 (mix_div2)
    );

    // channel divider chain, alpha rides along
    logic [CH_W:0]                          d2_valid;
    logic [CH_W:0][NUM_CH-1:0][NW2-1:0]     d2_rem;
    logic [CH_W:0][NUM_CH-1:0][CH_W-1:0]    d2_quot;
    logic [CH_W:0][DW:0]                    d2_div;
    logic [CH_W:0][CH_W-1:0]                d2_side;

    assign d2_valid[0] = mix_valid;
    assign d2_rem[0]   = mix_num;
    assign d2_quot[0]  = '0;
    assign d2_div[0]   = mix_div2;
    assign d2_side[0]  = ALPHA;

    for (genvar i = 0; i < CH_W; i++)
    begin : g_chan
        gpe_cell #(
            .LANES(NUM_CH), .NW(NW2), .DW(DW + 1), .QW(CH_W), .BIT(CH_W - 1 - i),
            .SW(CH_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (d2_valid[i]),
            .in_rem   (d2_rem[i]),
            .in_quot  (d2_quot[i]),
            .in_div   (d2_div[i]),
            .in_side  (d2_side[i]),
            .out_valid(d2_valid[i+1]),
            .out_rem  (d2_rem[i+1]),
            .out_quot (d2_quot[i+1]),
            .out_div  (d2_div[i+1]),
            .out_side (d2_side[i+1])
        );
    end

    // drive the result
    assign done        = d2_valid[CH_W];
    assign colour_argb = {d2_side[CH_W], d2_quot[CH_W][2], d2_quot[CH_W][1],
                          d2_quot[CH_W][0]};

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##(LAT - 1) done)
        else $error("result missing after pipeline latency");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (colour_argb[31:24] == ALPHA))
        else $error("alpha lost in channel chain");

    a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((d2_rem[CH_W][0] < NW2'(d2_div[CH_W])) &&
                  (d2_rem[CH_W][1] < NW2'(d2_div[CH_W])) &&
                  (d2_rem[CH_W][2] < NW2'(d2_div[CH_W]))))
        else $error("channel remainder not reduced");

endmodule

`default_nettype wire

// File: tb/gpe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpe_checker: palette entry predictor and result comparator
// Tracks register writes, predicts each accepted request's ARGB color and
// compares it with the colors returned on done, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [gpe_pkg::IDX_W-1:0]       step_index,
    input  wire logic                            done,
    input  wire logic [gpe_pkg::ARGB_W-1:0]      colour_argb,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [gpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gpe_pkg::PAIR_W-1:0]      cfg_data,
    output int                                   error_count,
    output int                                   colors_pending
);
    import gpe_pkg::*;

    logic [CNT_W-1:0]   stop_count_q;
    logic [STEPS_W-1:0] step_count_q;
    logic [PAIR_W-1:0]  stop_pair_q [4];
    logic [ARGB_W-1:0]  expected_colors [$];

    // Print one mismatch line and count it
    task automatic report(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [STOP_W-1:0] stop_color(input int k);
        logic [PAIR_W-1:0] pair;
        pair = stop_pair_q[k >> 1];
        return (k & 1) ? pair[47:24] : pair[23:0];
    endfunction

    // Compute the palette color for one step index under the current registers
    function automatic logic [ARGB_W-1:0] palette_color(input logic [IDX_W-1:0] idx);
        longint stops, steps, d, pos, num, q, r, k2, c1, c2, v;
        logic [STOP_W-1:0] s1, s2;
        logic [ARGB_W-1:0] argb;
        stops = stop_count_q;
        steps = step_count_q;
        if (stops < 1) stops = 1;
        if (stops > MAX_STOPS_DEF) stops = MAX_STOPS_DEF;
        if (steps < 2) steps = 2;
        if (steps > MAX_STEPS_DEF) steps = MAX_STEPS_DEF;
        d = steps - 1;
        pos = idx;
        if (pos > d) pos = d;
        num = pos * (stops - 1);
        q = num / d;
        r = num % d;
        if (q > stops - 1) q = stops - 1;
        k2 = q + 1;
        if (k2 > stops - 1) k2 = stops - 1;
        s1 = stop_color(int'(q));
        s2 = stop_color(int'(k2));
        argb = {ALPHA, 24'h0};
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            c1 = (s1 >> (ch * 8)) & 8'hFF;
            c2 = (s2 >> (ch * 8)) & 8'hFF;
            v = (2 * ((d - r) * c1 + r * c2) + d) / (2 * d);
            if (v > 255) v = 255;
            argb[ch*8 +: 8] = v[7:0];
        end
        return argb;
    endfunction

    assign colors_pending = expected_colors.size();

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_q <= STOP_COUNT_RST;
            step_count_q <= STEP_COUNT_RST;
            for (int i = 0; i < 4; i++) stop_pair_q[i] <= '0;
            expected_colors.delete();
            error_count = 0;
        end
        else
        begin
            if (start && !busy)
                expected_colors.push_back(palette_color(step_index));
            if (done)
            begin
                if (expected_colors.size() == 0)
                    report($sformatf("unexpected color %h", colour_argb));
                else
                begin
                    logic [ARGB_W-1:0] want;
                    want = expected_colors.pop_front();
                    if (colour_argb !== want)
                        report($sformatf("colour_argb %h, want %h", colour_argb, want));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_STOP_COUNT: stop_count_q <= cfg_data[CNT_W-1:0];
                    REG_STEP_COUNT: step_count_q <= cfg_data[STEPS_W-1:0];
                    REG_PAIR_0:     stop_pair_q[0] <= cfg_data;
                    REG_PAIR_1:     stop_pair_q[1] <= cfg_data;
                    REG_PAIR_2:     stop_pair_q[2] <= cfg_data;
                    REG_PAIR_3:     stop_pair_q[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: gradient palette entry testbench
// Drives step index requests under a range of stop and step settings with
// random gaps; the checker predicts and compares every color.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import gpe_pkg::*;

    localparam int  DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [IDX_W-1:0]     step_index;
    logic                 done;
    logic [ARGB_W-1:0]    colour_argb;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PAIR_W-1:0]    cfg_data;
    int                   error_count;
    int                   colors_pending;
    longint               cycle_count;
    logic [12:0]          cur_steps;

    gradient_palette_entry u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .step_index(step_index), .done(done), .colour_argb(colour_argb),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gpe_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .step_index(step_index), .done(done), .colour_argb(colour_argb),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .colors_pending(colors_pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Stop the run on a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Write one register once the port is ready; valid stays up for the next write
    task automatic write_reg(input cfg_reg_t idx, input logic [PAIR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Send one request after a random gap; start stays up for a back-to-back request
    task automatic send_index(input logic [IDX_W-1:0] idx, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        step_index <= idx;
        do @(posedge clk); while (busy);
    endtask

    // Drop start, let all results arrive, then give the pipeline time to settle
    task automatic drain();
        start <= 1'b0;
        while (colors_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PAIR_W-1:0] rand_pair();
        return PAIR_W'({$urandom(), $urandom()});
    endfunction

    // Program a full register setting
    task automatic program_regs(input logic [3:0] stops, input logic [12:0] steps,
                                input bit extremes);
        write_reg(REG_STOP_COUNT, PAIR_W'(stops));
        write_reg(REG_STEP_COUNT, PAIR_W'(steps));
        cur_steps = steps;
        write_reg(REG_PAIR_0, extremes ? 48'hFFFFFF_000000 : rand_pair());
        write_reg(REG_PAIR_1, extremes ? 48'h000000_FFFFFF : rand_pair());
        write_reg(REG_PAIR_2, extremes ? 48'hFFFFFF_FFFFFF : rand_pair());
        write_reg(REG_PAIR_3, extremes ? 48'h000000_000000 : rand_pair());
        cfg_valid <= 1'b0;
    endtask

    // Index biased toward the palette range, with some past its end
    function automatic logic [IDX_W-1:0] pick_index();
        int lim;
        lim = (cur_steps < 2) ? 1 : ((cur_steps > 4096) ? 4095 : cur_steps - 1);
        if ($urandom_range(0, 9) == 0) return IDX_W'($urandom());
        return IDX_W'($urandom_range(0, lim));
    endfunction

    initial
    begin
        logic [3:0]  stops;
        logic [12:0] steps;
        rst_n       = 1'b0;
        start       = 1'b0;
        step_index  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycle_count = 0;
        cur_steps   = 13'd256;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, then extreme registers and edge indexes
        send_index(12'd0, 1'b0);
        send_index(12'hFFF, 1'b0);
        drain();
        program_regs(4'd8, 13'd4096, 1'b1);
        send_index(12'd0, 1'b0);
        send_index(12'd1, 1'b0);
        send_index(12'd2048, 1'b0);
        send_index(12'hFFF, 1'b0);
        send_index(12'hAAA, 1'b0);
        send_index(12'h555, 1'b0);
        drain();
        program_regs(4'd1, 13'd2, 1'b0);
        send_index(12'd0, 1'b0);
        send_index(12'd1, 1'b0);
        send_index(12'hFFF, 1'b0);
        drain();
        program_regs(4'd0, 13'd0, 1'b0);
        send_index(12'd0, 1'b0);
        send_index(12'd5, 1'b0);
        drain();
        program_regs(4'hF, 13'h1FFF, 1'b0);
        send_index(12'd100, 1'b0);
        send_index(12'hFFF, 1'b0);
        drain();
        program_regs(4'd2, 13'd1, 1'b1);
        send_index(12'd0, 1'b0);
        send_index(12'd1, 1'b0);
        drain();

        // Random settings, each with a burst of requests
        for (int phase = 0; phase < 34; phase++)
        begin
            stops = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8));
            case ($urandom_range(0, 5))
                0: steps = 13'($urandom());
                1: steps = 13'd4096;
                2: steps = 13'($urandom_range(2, 4));
                default: steps = 13'($urandom_range(2, 300));
            endcase
            program_regs(stops, steps, 1'b0);
            for (int n = 0; n < 50; n++)
                send_index(pick_index(), (phase % 3) != 0);
            drain();
        end

        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: gradient_palette_entry.f
hdl/gpe_pkg.sv
hdl/gpe_cell.sv
hdl/gpe_mix.sv
hdl/gradient_palette_entry.sv
tb/gpe_checker.sv
tb/tb.sv
